// ===== rtl/psum_pkg.sv =====
// Shared types and constants for the prime sum block.
package psum_pkg;

   localparam int LIMIT_WIDTH = 16;
   localparam int SUM_BITS    = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_TEST,
      ST_DIV,
      ST_REM,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath; at most one is set per cycle.
   typedef struct packed {
      logic load;
      logic cand_init;
      logic add_next;
      logic skip_next;
      logic div_start;
      logic div_step;
      logic d_next;
      logic publish;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic scan_done;
      logic sq_above;
      logic div_last;
      logic rem_zero;
      logic slot_free;
   } status_type;

endpackage

// ===== rtl/psum_ctrl.sv =====
// Controller state machine for the prime sum block.
module psum_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  psum_pkg::status_type status,
   output psum_pkg::cmd_type    cmd
);
   import psum_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.cand_init = 1'b1;
               state_in      = ST_TEST;
            end
         end
         ST_TEST: begin
            // no divisor left with d*d <= k: candidate is prime
            if (status.sq_above) begin
               cmd.add_next = 1'b1;
               state_in     = ST_CAND;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_REM;
            end
         end
         ST_REM: begin
            if (status.rem_zero) begin
               cmd.skip_next = 1'b1;
               state_in      = ST_CAND;
            end else begin
               cmd.d_next = 1'b1;
               state_in   = ST_TEST;
            end
         end
         ST_FINISH: begin
            if (status.slot_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/psum_dpath.sv =====
// Datapath for the prime sum block: candidate, divisor, remainder unit, sum, output register.
module psum_dpath #(
   parameter int LIM_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_has_value,
   input  logic [psum_pkg::LIMIT_WIDTH-1:0]   req_limit_value,
   input  psum_pkg::cmd_type                  cmd,
   output psum_pkg::status_type               status,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [psum_pkg::SUM_BITS-1:0]      rsp_prime_sum
);
   import psum_pkg::*;

   localparam int SQ_BITS  = 2 * LIM_BITS;
   localparam int CNT_BITS = $clog2(LIM_BITS);

   logic [LIM_BITS-1:0] limit_ff;
   logic                no_scan_ff;
   logic [LIM_BITS:0]   k_ff;
   logic [LIM_BITS-1:0] d_ff;
   logic [SQ_BITS-1:0]  sq_ff;
   logic [LIM_BITS-1:0] q_ff;
   logic [LIM_BITS-1:0] r_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [SUM_BITS-1:0] sum_ff;
   logic                rsp_valid_ff;
   logic [SUM_BITS-1:0] rsp_sum_ff;

   logic [LIM_BITS-1:0] limit_in;
   logic [LIM_BITS:0]   trial;
   logic [LIM_BITS-1:0] r_in;

   assign limit_in = req_limit_value[LIM_BITS-1:0];

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {r_ff, q_ff[LIM_BITS-1]};
   assign r_in  = (trial >= {1'b0, d_ff}) ? LIM_BITS'(trial - {1'b0, d_ff})
                                          : trial[LIM_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         limit_ff   <= limit_in;
         no_scan_ff <= ~req_has_value | (limit_in < LIM_BITS'(2));
         sum_ff     <= (req_has_value && limit_in == LIM_BITS'(1)) ? SUM_BITS'(1)
                                                                   : '0;
         k_ff       <= (LIM_BITS + 1)'(2);
      end
      if (cmd.cand_init) begin
         d_ff  <= LIM_BITS'(2);
         sq_ff <= SQ_BITS'(4);
      end
      if (cmd.add_next) begin
         sum_ff <= sum_ff + SUM_BITS'(k_ff);
         k_ff   <= k_ff + (LIM_BITS + 1)'(1);
      end
      if (cmd.skip_next) begin
         k_ff <= k_ff + (LIM_BITS + 1)'(1);
      end
      if (cmd.div_start) begin
         q_ff   <= k_ff[LIM_BITS-1:0];
         r_ff   <= '0;
         cnt_ff <= CNT_BITS'(LIM_BITS - 1);
      end
      if (cmd.div_step) begin
         r_ff   <= r_in;
         q_ff   <= {q_ff[LIM_BITS-2:0], 1'b0};
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
      if (cmd.d_next) begin
         // (d+1)^2 = d^2 + 2d + 1
         d_ff  <= d_ff + LIM_BITS'(1);
         sq_ff <= sq_ff + SQ_BITS'({d_ff, 1'b0}) + SQ_BITS'(1);
      end
      if (cmd.publish) begin
         rsp_sum_ff <= sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.scan_done = no_scan_ff | (k_ff > {1'b0, limit_ff});
   assign status.sq_above  = sq_ff > SQ_BITS'(k_ff);
   assign status.div_last  = (cnt_ff == '0);
   assign status.rem_zero  = (r_ff == '0);
   assign status.slot_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_prime_sum = rsp_sum_ff;

endmodule

// ===== rtl/prime_sum_up_to_n.sv =====
// Top level of the prime sum block: controller plus datapath.
//
// Usage:
//   Request channel (req_valid/req_ready) carries req_has_value and
//   req_limit_value. Each transaction yields exactly one response transaction
//   on rsp_valid/rsp_ready carrying rsp_prime_sum, the sum of all primes
//   from 2 up to the limit. No number (has_value low) or a limit of 0 gives 0,
//   and a limit of exactly 1 gives 1.
//   Only the low min(VALUE_BITS,16) bits of the limit are used.
//   Primality of each candidate k is decided by trial division, one divisor
//   at a time, through a bit-serial remainder unit that retires one dividend
//   bit per cycle. Each divisor passes through a test, LIM_BITS remainder
//   steps and a check of the remainder; each candidate also passes through a
//   setup state, and a prime ends with one more test.
//   One request is worked at a time; req_ready is high only while idle.
//   The result sits in an output register, so a new request is taken while
//   the previous response still waits; a finished result then holds until
//   the receiver frees the register.
//   Reset (synchronous, active high) returns the controller to idle and drops
//   any pending response.
module prime_sum_up_to_n #(
   parameter int VALUE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_has_value,
   input  logic [psum_pkg::LIMIT_WIDTH-1:0] req_limit_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [psum_pkg::SUM_BITS-1:0]    rsp_prime_sum
);
   import psum_pkg::*;

   // the limit field is 16 bits wide, so wider settings use all of it
   localparam int LIM_BITS = (VALUE_BITS < LIMIT_WIDTH) ? VALUE_BITS : LIMIT_WIDTH;

   cmd_type    cmd;
   status_type status;

   psum_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   psum_dpath #(
      .LIM_BITS (LIM_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_has_value   (req_has_value),
      .req_limit_value (req_limit_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_sum   (rsp_prime_sum)
   );

endmodule
